### hdl/yolo_cell_decode_macros.svh
`ifndef YOLO_CELL_DECODE_MACROS_SVH
`define YOLO_CELL_DECODE_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define YCD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define YCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ycd_pkg.sv
package ycd_pkg;

  // logit width and class limit
  localparam int LOGIT_BITS  = 16;
  localparam int MAX_CLASSES = 80;

  // magnitude width, at least wide enough for the 8.0 saturation point
  localparam int MAG_W  = (LOGIT_BITS + 1 > 12) ? LOGIT_BITS + 1 : 12;
  localparam int PROB_W = 16;

  // element index of the objectness logit and of the first class score
  localparam int OBJ_INDEX   = 4;
  localparam int CLASS_FIRST = 5;

  // sigmoid knots at k/2 for k = 0..16, Q0.16
  localparam logic [PROB_W-1:0] SIG_TABLE [17] = '{
    16'd32768, 16'd40793, 16'd47911, 16'd53581, 16'd57724, 16'd60565,
    16'd62428, 16'd63615, 16'd64357, 16'd64816, 16'd65097, 16'd65269,
    16'd65374, 16'd65438, 16'd65476, 16'd65500, 16'd65514
  };

  // register reset values
  localparam logic [15:0] THRESHOLD_RESET = 16'd32768;
  localparam logic [6:0]  STRIDE_RESET    = 7'd8;
  localparam logic [8:0]  ANCHOR_RESET [6] = '{
    9'd10, 9'd13, 9'd16, 9'd30, 9'd32, 9'd23
  };

  // configuration register map
  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_STRIDE    = 3'd1,
    REG_ANCHOR_WA = 3'd2,
    REG_ANCHOR_HA = 3'd3,
    REG_ANCHOR_WB = 3'd4,
    REG_ANCHOR_HB = 3'd5,
    REG_ANCHOR_WC = 3'd6,
    REG_ANCHOR_HC = 3'd7
  } cfg_reg_t;

  // box dimension being decoded, sizes first so the corners can use them
  typedef enum logic [1:0] {
    DIM_W = 2'd0,
    DIM_H = 2'd1,
    DIM_X = 2'd2,
    DIM_Y = 2'd3
  } box_dim_t;

  typedef enum logic [3:0] {
    ST_RUN,
    ST_LAST,
    ST_CONF,
    ST_GATE,
    ST_SIG,
    ST_MUL1,
    ST_MUL2,
    ST_RND,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic signed [LOGIT_BITS-1:0] logit;
    logic [7:0]                   cell_column;
    logic [7:0]                   cell_row;
    logic [1:0]                   anchor_slot;
    logic                         end_of_cell;
  } item_t;

  typedef struct packed {
    logic signed [11:0] box_left;
    logic signed [11:0] box_top;
    logic [10:0]        box_width;
    logic [10:0]        box_height;
    logic [15:0]        confidence;
    logic [7:0]         class_index;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic     take;
    logic     conf_mul;
    logic     box_sig;
    logic     box_mul1;
    logic     box_mul2;
    logic     box_rnd;
    box_dim_t dim;
    logic     load_out;
    logic     clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic item_last;
    logic drop;
    logic out_free;
  } status_t;

endpackage

### hdl/ycd_sigmoid.sv
module ycd_sigmoid import ycd_pkg::*; (
  input  logic signed [LOGIT_BITS-1:0] logit,
  output logic [PROB_W-1:0]            prob
);

  logic signed [MAG_W-1:0] ext;
  logic [MAG_W-1:0]        mag;
  logic                    sat;
  logic [3:0]              seg;
  logic [6:0]              frac;
  logic [PROB_W-1:0]       lo;
  logic [PROB_W-1:0]       hi;
  logic [PROB_W+6:0]       slope;
  logic [PROB_W-1:0]       pos_prob;

  // piecewise-linear sigmoid on |logit|, mirrored for negative input
  always_comb begin
    ext      = MAG_W'(logit);
    mag      = logit[LOGIT_BITS-1] ? MAG_W'(-ext) : MAG_W'(ext);
    sat      = (mag >= MAG_W'(2048));
    seg      = mag[10:7];
    frac     = mag[6:0];
    lo       = SIG_TABLE[5'(seg)];
    hi       = SIG_TABLE[5'(seg) + 5'd1];
    slope    = ((PROB_W+7)'(hi - lo) * (PROB_W+7)'(frac) + (PROB_W+7)'(64)) >> 7;
    pos_prob = sat ? {PROB_W{1'b1}} : PROB_W'(lo + PROB_W'(slope));
    prob     = logit[LOGIT_BITS-1] ? PROB_W'(17'd65536 - 17'(pos_prob)) : pos_prob;
  end

endmodule

### hdl/ycd_ctrl.sv
module ycd_ctrl import ycd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t   state;
  state_t   state_next;
  box_dim_t dim;
  box_dim_t dim_next;

  // state and dimension registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      dim   <= DIM_W;
    end else begin
      state <= state_next;
      dim   <= dim_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    dim_next   = dim;
    case (state)
      ST_RUN: begin
        if (item_valid && status.item_last) state_next = ST_LAST;
      end
      ST_LAST: state_next = ST_CONF;
      ST_CONF: state_next = ST_GATE;
      ST_GATE: begin
        dim_next   = DIM_W;
        state_next = status.drop ? ST_RUN : ST_SIG;
      end
      ST_SIG:  state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_RND;
      ST_RND: begin
        dim_next   = box_dim_t'(dim + 2'd1);
        state_next = (dim == DIM_Y) ? ST_LOAD : ST_SIG;
      end
      ST_LOAD: begin
        if (status.out_free) state_next = ST_RUN;
      end
      default: state_next = ST_RUN;
    endcase
  end

  // outputs
  always_comb begin
    item_ready   = (state == ST_RUN);
    cmd.take     = item_valid && (state == ST_RUN);
    cmd.conf_mul = (state == ST_CONF);
    cmd.box_sig  = (state == ST_SIG);
    cmd.box_mul1 = (state == ST_MUL1);
    cmd.box_mul2 = (state == ST_MUL2);
    cmd.box_rnd  = (state == ST_RND);
    cmd.dim      = dim;
    cmd.load_out = (state == ST_LOAD) && status.out_free;
    cmd.clear    = ((state == ST_GATE) && status.drop) ||
                   ((state == ST_LOAD) && status.out_free);
  end

endmodule

### hdl/ycd_dpath.sv
module ycd_dpath import ycd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  item_t       item,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  cmd_t        cmd,
  output status_t     status,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result
);

  // configuration
  logic [15:0] thr;
  logic [6:0]  stride;
  logic [8:0]  anch [6];

  // held beat and cell state
  logic                         h_valid;
  logic signed [LOGIT_BITS-1:0] h_logit;
  logic [7:0]                   h_idx;
  logic [7:0]                   h_col;
  logic [7:0]                   h_row;
  logic [1:0]                   h_slot;
  logic [7:0]                   elem_count;
  logic signed [LOGIT_BITS-1:0] box_logits [4];
  logic [PROB_W-1:0]            objness;
  logic [PROB_W-1:0]            best_prob;
  logic [7:0]                   best_class;
  logic [15:0]                  conf;

  // box decode registers
  logic [PROB_W-1:0]  s_reg;
  logic signed [33:0] prod1;
  logic [42:0]        bw_q;
  logic [42:0]        bh_q;
  logic signed [49:0] val;
  logic signed [11:0] res_left;
  logic signed [11:0] res_top;
  logic [10:0]        res_width;
  logic [10:0]        res_height;

  // combinational
  logic signed [LOGIT_BITS-1:0] sig_in;
  logic [PROB_W-1:0]            sig_out;
  logic                         is_class;
  logic [7:0]                   pos;
  logic signed [25:0]           ctr_u;
  logic [1:0]                   slot_c;
  logic [2:0]                   aidx;
  logic [42:0]                  area_q;
  logic [48:0]                  mag;
  logic [17:0]                  rmag;
  logic signed [11:0]           rnd_s;
  logic [10:0]                  rnd_u;

  // shared sigmoid: held beat while streaming, box logits while decoding
  assign sig_in = cmd.box_sig ? box_logits[2'(cmd.dim) ^ 2'b10] : h_logit;

  ycd_sigmoid u_sigmoid (
    .logit (sig_in),
    .prob  (sig_out)
  );

  // status back to the controller
  always_comb begin
    status.item_last = item.end_of_cell;
    status.drop      = (h_idx < 8'(CLASS_FIRST)) || (objness < thr) || (conf < thr);
    status.out_free  = !result_valid || result_ready;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      thr    <= THRESHOLD_RESET;
      stride <= STRIDE_RESET;
      for (int i = 0; i < 6; i++) begin
        anch[i] <= ANCHOR_RESET[i];
      end
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD: thr     <= cfg_data;
        REG_STRIDE:    stride  <= cfg_data[6:0];
        REG_ANCHOR_WA: anch[0] <= cfg_data[8:0];
        REG_ANCHOR_HA: anch[1] <= cfg_data[8:0];
        REG_ANCHOR_WB: anch[2] <= cfg_data[8:0];
        REG_ANCHOR_HB: anch[3] <= cfg_data[8:0];
        REG_ANCHOR_WC: anch[4] <= cfg_data[8:0];
        REG_ANCHOR_HC: anch[5] <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // capture the input beat
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      h_logit <= item.logit;
      h_idx   <= elem_count;
      h_col   <= item.cell_column;
      h_row   <= item.cell_row;
      h_slot  <= item.anchor_slot;
    end
  end

  assign is_class = (h_idx >= 8'(CLASS_FIRST)) &&
                    (9'(h_idx) < 9'(CLASS_FIRST + MAX_CLASSES));

  // cell state: position count, objectness, running best class
  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid    <= 1'b0;
      elem_count <= '0;
      objness    <= '0;
      best_prob  <= '0;
      best_class <= '0;
    end else begin
      h_valid <= cmd.take;
      if (cmd.clear) begin
        elem_count <= '0;
        objness    <= '0;
        best_prob  <= '0;
        best_class <= '0;
      end else begin
        if (cmd.take && (elem_count != 8'hFF)) begin
          elem_count <= elem_count + 8'd1;
        end
        if (h_valid) begin
          if (h_idx == 8'(OBJ_INDEX)) begin
            objness <= sig_out;
          end else if (is_class && (sig_out > best_prob)) begin
            best_prob  <= sig_out;
            best_class <= h_idx - 8'(CLASS_FIRST);
          end
        end
      end
    end
  end

  // raw box logits
  always_ff @(posedge clk) begin
    if (h_valid && (h_idx < 8'(OBJ_INDEX))) begin
      box_logits[h_idx[1:0]] <= h_logit;
    end
  end

  // combined confidence, rounded
  always_ff @(posedge clk) begin
    if (cmd.conf_mul) begin
      conf <= 16'((32'(objness) * 32'(best_prob) + 32'd32768) >> 16);
    end
  end

  // operand selection for the box multiplies
  always_comb begin
    pos    = (cmd.dim == DIM_X) ? h_col : h_row;
    ctr_u  = $signed(26'({s_reg, 1'b0})) - 26'sd32768 + $signed(26'({pos, 16'h0000}));
    slot_c = (h_slot > 2'd2) ? 2'd2 : h_slot;
    aidx   = 3'({slot_c, 1'b0}) | 3'(cmd.dim == DIM_H);
    area_q = (43'(prod1[31:0]) * 43'(anch[aidx])) << 2;
  end

  // rounding half away from zero out of Q.32, then saturation
  always_comb begin
    mag  = val[49] ? 49'(-val) : 49'(val);
    rmag = 18'((50'(mag) + 50'h0_0000_8000_0000) >> 32);
    if (val[49]) begin
      rnd_s = (rmag >= 18'd2048) ? -12'sd2048 : -$signed(12'(rmag));
      rnd_u = '0;
    end else begin
      rnd_s = (rmag > 18'd2047) ? 12'sd2047 : $signed(12'(rmag));
      rnd_u = (rmag > 18'd2047) ? 11'h7FF : 11'(rmag);
    end
  end

  // box decode sequence, one step per cycle
  always_ff @(posedge clk) begin
    if (cmd.box_sig) begin
      s_reg <= sig_out;
    end
    if (cmd.box_mul1) begin
      if ((cmd.dim == DIM_W) || (cmd.dim == DIM_H)) begin
        prod1 <= $signed(34'(32'(s_reg) * 32'(s_reg)));
      end else begin
        prod1 <= 34'(ctr_u) * 34'($signed({1'b0, stride}));
      end
    end
    if (cmd.box_mul2) begin
      case (cmd.dim)
        DIM_W: begin
          bw_q <= area_q;
          val  <= $signed(50'(area_q));
        end
        DIM_H: begin
          bh_q <= area_q;
          val  <= $signed(50'(area_q));
        end
        DIM_X: val <= ($signed(50'(prod1)) <<< 16) - $signed(50'(bw_q >> 1));
        DIM_Y: val <= ($signed(50'(prod1)) <<< 16) - $signed(50'(bh_q >> 1));
        default: ;
      endcase
    end
    if (cmd.box_rnd) begin
      case (cmd.dim)
        DIM_W:   res_width  <= rnd_u;
        DIM_H:   res_height <= rnd_u;
        DIM_X:   res_left   <= rnd_s;
        DIM_Y:   res_top    <= rnd_s;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.box_left    <= res_left;
      result.box_top     <= res_top;
      result.box_width   <= res_width;
      result.box_height  <= res_height;
      result.confidence  <= conf;
      result.class_index <= best_class;
    end
  end

endmodule

### hdl/yolo_cell_decode.sv
// Detection-head cell decoder. Logits stream in one beat per cycle (x, y, w, h,
// objectness, class scores); the beat with end_of_cell closes the cell. Each
// logit is registered and passed through a shared sigmoid table the next cycle,
// where it updates objectness or the running best class. Closing a cell holds
// off input for the finish: a dropped cell runs only the threshold checks, an
// emitted one the threshold checks, then sigmoid, multiply, multiply and round
// for each of w, h, x and y on one multiplier chain, then the load into the
// output register, which waits as long as an earlier box is still untaken.
// The output register lets the next cell stream in while a box waits to be
// taken. Configuration writes are always ready and must only be made while no
// cell is in progress.
module yolo_cell_decode import ycd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  // register writes are always accepted
  assign cfg_ready = 1'b1;

  ycd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  ycd_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

### hdl/ycd_checker.sv
`include "yolo_cell_decode_macros.svh"

module ycd_checker import ycd_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input item_t   item,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  // a waiting result beat holds
  `YCD_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result), "result beat changed while stalled")

  // closing a cell stops input for the finish
  `YCD_ASSERT_NEXT(a_close_stalls, clk, rst, item_valid && item_ready && item.end_of_cell, !item_ready, "input taken right after a closing beat")

  // a new result only comes out of the finish sequence
  `YCD_ASSERT_NOW(a_result_after_finish, clk, rst, $rose(result_valid), !$past(item_ready), "result appeared while streaming")

  // reported class is within the class range
  `YCD_ASSERT_NOW(a_class_range, clk, rst, result_valid, result.class_index < 8'(MAX_CLASSES), "class index out of range")

endmodule

bind yolo_cell_decode ycd_checker u_checker (.*);
